// ----- hdl/cbs_pkg.sv -----
// Package with shared constants and types of the centroid bounding sphere block.
package cbs_pkg;

  localparam int CBS_MAX_VERTICES = 1024;
  localparam int CBS_COORD_BITS   = 24;

  localparam int CBS_POS_W     = 24;
  localparam int CBS_RADIUS_W  = 25;
  localparam int CBS_COUNT_W   = 11;
  localparam int CBS_IN_DATA_W  = 72;
  localparam int CBS_OUT_DATA_W = 112;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PASS,
    ST_ROOT,
    ST_EMIT
  } cbs_state_e;

endpackage

// ----- hdl/cbs_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
module cbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/cbs_div.sv -----
// Iterative restoring divider for unsigned operands, one quotient bit per cycle.
module cbs_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_sub;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ----- hdl/centroid_bounding_sphere.sv -----
// Top level of the centroid bounding sphere block: vertex store, center, distance pass, root.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48]; tlast: last
//  m_axis   | out       | tdata: center_x, center_y, center_z, radius, count, overflow
//
// Each vertex transfer goes into the vertex RAM while there is room; extra ones set overflow.
// After the last vertex: three serial divisions, a distance pass through the RAM read port
// and the squaring pipeline, then a bit-serial square root and a load of the result.
// Reset clears the sums, count and control; the RAM needs no clearing.
// A pending result does not block the next set from loading.
module centroid_bounding_sphere #(
  parameter int MAX_VERTICES = cbs_pkg::CBS_MAX_VERTICES,
  parameter int COORD_BITS   = cbs_pkg::CBS_COORD_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Fields from bit 0: pos_x (24), pos_y (24), pos_z (24).
  input  logic [cbs_pkg::CBS_IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // Fields from bit 0: center_x (24), center_y (24), center_z (24), radius (25),
  // count (11), overflow (1), then three zero bits.
  output logic [cbs_pkg::CBS_OUT_DATA_W-1:0] m_axis_tdata_o
);

  import cbs_pkg::*;

  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SUM_W   = COORD_BITS + CNT_W;
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int DIST_W  = 2 * COORD_BITS + 2;
  localparam int ROOT_W  = COORD_BITS + 1;
  localparam int RCNT_W  = $clog2(ROOT_W + 1);
  localparam int MEM_W   = 3 * COORD_BITS;
  localparam int CEXT_W  = (CNT_W > CBS_COUNT_W) ? CNT_W : CBS_COUNT_W;
  localparam int PAD_W   = CBS_OUT_DATA_W - 3 * CBS_POS_W - CBS_RADIUS_W - CBS_COUNT_W - 1;

  cbs_state_e state_q, state_d;

  logic signed [SUM_W-1:0]      sum_q [3];
  logic [CNT_W-1:0]             count_q;
  logic                         dropped_q;
  logic [DIST_W-1:0]            max_q;
  logic [1:0]                   axis_q;
  logic                         neg_q;
  logic signed [COORD_BITS-1:0] cen_q [3];

  logic [CNT_W-1:0]             issue_q;
  logic                         p1_q, p2_q, p3_q, p4_q;
  logic signed [DIFF_W-1:0]     diff_q [3];
  logic [SQ_W-1:0]              sq_q [3];
  logic [DIST_W-1:0]            dist_q;

  logic [DIST_W-1:0]            rad_q;
  logic [ROOT_W:0]              rem_q;
  logic [ROOT_W-1:0]            root_q;
  logic [RCNT_W-1:0]            rcnt_q;

  logic                         m_valid_q;
  logic [CBS_OUT_DATA_W-1:0]    m_data_q;

  logic signed [COORD_BITS-1:0] in_c [3];
  logic                         in_xfer;
  logic                         has_room;
  logic                         issue_en;
  logic                         div_start;
  logic                         div_done;
  logic [SUM_W-1:0]             div_num;
  logic [SUM_W-1:0]             div_quot;
  logic signed [SUM_W-1:0]      sel_sum;
  logic [SUM_W-1:0]             quot_signed;
  logic [MEM_W-1:0]             rd_data;
  logic signed [COORD_BITS-1:0] rd_c [3];
  logic signed [2*DIFF_W-1:0]   prod [3];
  logic                         out_free;
  logic [ROOT_W+2:0]            rem_sh;
  logic [ROOT_W+2:0]            trial;
  logic                         root_fits;
  logic [ROOT_W+2:0]            rem_sub;
  logic [CEXT_W-1:0]            count_ext;

  assign in_c[0] = s_axis_tdata_i[COORD_BITS-1:0];
  assign in_c[1] = s_axis_tdata_i[CBS_POS_W+COORD_BITS-1:CBS_POS_W];
  assign in_c[2] = s_axis_tdata_i[2*CBS_POS_W+COORD_BITS-1:2*CBS_POS_W];

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign has_room = count_q < CNT_W'(MAX_VERTICES);
  assign issue_en = (state_q == ST_PASS) && (issue_q != count_q);
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign sel_sum     = sum_q[axis_q];
  assign div_num     = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
  assign quot_signed = neg_q ? (~div_quot + 1'b1) : div_quot;

  assign rd_c[0] = rd_data[COORD_BITS-1:0];
  assign rd_c[1] = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_c[2] = rd_data[3*COORD_BITS-1:2*COORD_BITS];

  assign rem_sh    = {rem_q, rad_q[DIST_W-1:DIST_W-2]};
  assign trial     = {2'b00, root_q, 1'b0} << 1 | (ROOT_W+3)'(1);
  assign root_fits = rem_sh >= trial;
  assign rem_sub   = rem_sh - trial;

  assign count_ext = CEXT_W'(count_q);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = diff_q[a] * diff_q[a];
    end
  end

  cbs_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_VERTICES),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (in_xfer && has_room),
    .waddr_i(count_q[ADDR_W-1:0]),
    .wdata_i({in_c[2], in_c[1], in_c[0]}),
    .raddr_i(issue_q[ADDR_W-1:0]),
    .rdata_o(rd_data)
  );

  cbs_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (count_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && s_axis_tlast_i) begin
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (axis_q == 2'd2) ? ST_PASS : ST_DIV_START;
        end
      end
      ST_PASS: begin
        if (!issue_en && !p1_q && !p2_q && !p3_q && !p4_q) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rcnt_q == RCNT_W'(ROOT_W - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= '0;
      end
      count_q   <= '0;
      dropped_q <= 1'b0;
      max_q     <= '0;
      axis_q    <= '0;
      issue_q   <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      p3_q      <= 1'b0;
      p4_q      <= 1'b0;
      rcnt_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      p1_q <= issue_en;
      p2_q <= p1_q;
      p3_q <= p2_q;
      p4_q <= p3_q;
      if ((state_q == ST_EMIT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          axis_q  <= '0;
          issue_q <= '0;
          if (in_xfer) begin
            if (has_room) begin
              for (int a = 0; a < 3; a++) begin
                sum_q[a] <= sum_q[a] + SUM_W'(in_c[a]);
              end
              count_q <= count_q + 1'b1;
            end else begin
              dropped_q <= 1'b1;
            end
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            axis_q <= axis_q + 1'b1;
          end
        end
        ST_PASS: begin
          rcnt_q <= '0;
          if (issue_en) begin
            issue_q <= issue_q + 1'b1;
          end
          if (p4_q && (dist_q > max_q)) begin
            max_q <= dist_q;
          end
        end
        ST_ROOT: begin
          rcnt_q <= rcnt_q + 1'b1;
        end
        ST_EMIT: begin
          if (out_free) begin
            for (int a = 0; a < 3; a++) begin
              sum_q[a] <= '0;
            end
            count_q   <= '0;
            dropped_q <= 1'b0;
            max_q     <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      neg_q <= sel_sum[SUM_W-1];
    end
    if ((state_q == ST_DIV_WAIT) && div_done) begin
      cen_q[axis_q] <= quot_signed[COORD_BITS-1:0];
    end
    if (p1_q) begin
      for (int a = 0; a < 3; a++) begin
        diff_q[a] <= DIFF_W'(rd_c[a]) - DIFF_W'(cen_q[a]);
      end
    end
    if (p2_q) begin
      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= prod[a][SQ_W-1:0];
      end
    end
    if (p3_q) begin
      dist_q <= DIST_W'(sq_q[0]) + DIST_W'(sq_q[1]) + DIST_W'(sq_q[2]);
    end
    if (state_q == ST_PASS) begin
      rad_q  <= max_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == ST_ROOT) begin
      rad_q  <= rad_q << 2;
      rem_q  <= root_fits ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], root_fits};
    end
    if ((state_q == ST_EMIT) && out_free) begin
      m_data_q <= {PAD_W'(0),
                   dropped_q,
                   count_ext[CBS_COUNT_W-1:0],
                   CBS_RADIUS_W'(root_q),
                   CBS_POS_W'(cen_q[2]),
                   CBS_POS_W'(cen_q[1]),
                   CBS_POS_W'(cen_q[0])};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
